>>> rtl/fqfa_pkg.sv
package fqfa_pkg;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    localparam logic [7:0] MARKER_RESET = 8'h40;
    localparam logic FASTQ_RESET = 1'b1;

    localparam logic CFG_RECORD_MARKER = 1'b0;
    localparam logic CFG_FASTQ_MODE = 1'b1;

    localparam logic [1:0] LAST_LINE_FASTQ = 2'd3;
    localparam logic [1:0] LAST_LINE_FASTA = 2'd1;

    localparam logic [2:0] KIND_BREAK = 3'd4;
    localparam logic [2:0] KIND_IGNORED = 3'd5;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_BAD_START = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;

    typedef enum logic [3:0] {
        PH_AWAIT = 4'b0001,
        PH_LINE  = 4'b0010,
        PH_BREAK = 4'b0100,
        PH_ERROR = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] marker;
        logic       fastq;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] line_kind;
        logic       record_start;
        logic       record_done;
        logic [1:0] error_code;
        logic       block_done;
    } result_t;

endpackage

>>> rtl/fqfa_cfg.sv
module fqfa_cfg
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_addr,
    input  logic [7:0]      cfg_data,
    output fqfa_pkg::cfg_t  cfg
);
    import fqfa_pkg::*;

    logic [7:0] marker_reg;
    logic [7:0] marker_next;
    logic       fastq_reg;
    logic       fastq_next;

    always_comb
    begin
        marker_next = marker_reg;
        fastq_next = fastq_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_RECORD_MARKER: marker_next = cfg_data;
                CFG_FASTQ_MODE:    fastq_next = cfg_data[0];
                default:           marker_next = marker_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= MARKER_RESET;
            fastq_reg <= FASTQ_RESET;
        end
        else
        begin
            marker_reg <= marker_next;
            fastq_reg <= fastq_next;
        end
    end

    assign cfg.marker = marker_reg;
    assign cfg.fastq = fastq_reg;

endmodule

>>> rtl/fqfa_parse.sv
module fqfa_parse
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  fqfa_pkg::cfg_t     cfg,
    input  logic [7:0]         data_byte,
    input  logic               block_end,
    output fqfa_pkg::result_t  res
);
    import fqfa_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [1:0] line_reg;
    logic [1:0] line_next;
    logic [1:0] last_line;
    logic       is_brk;
    logic       await_mark;

    assign last_line = cfg.fastq ? LAST_LINE_FASTQ : LAST_LINE_FASTA;
    assign is_brk = (data_byte == CHAR_LF) || (data_byte == CHAR_CR);

    always_comb
    begin
        phase_next = phase_reg;
        line_next = line_reg;
        await_mark = 1'b0;
        res.out_byte = data_byte;
        res.line_kind = KIND_IGNORED;
        res.record_start = 1'b0;
        res.record_done = 1'b0;
        res.error_code = ERR_NONE;
        res.block_done = block_end;

        case (phase_reg)
            PH_LINE:
            begin
                if (is_brk)
                begin
                    res.out_byte = BYTE_ZERO;
                    res.line_kind = KIND_BREAK;
                    phase_next = PH_BREAK;
                end
                else
                begin
                    res.line_kind = {1'b0, line_reg};
                end
            end
            PH_BREAK:
            begin
                if (is_brk)
                begin
                    res.out_byte = BYTE_ZERO;
                    res.line_kind = KIND_BREAK;
                end
                else if (line_reg < last_line)
                begin
                    line_next = line_reg + 2'd1;
                    phase_next = PH_LINE;
                    res.line_kind = {1'b0, line_next};
                    res.record_done = (line_next >= last_line);
                end
                else
                begin
                    await_mark = 1'b1;
                end
            end
            PH_AWAIT:
            begin
                await_mark = 1'b1;
            end
            default:
            begin
                phase_next = PH_ERROR;
            end
        endcase

        if (await_mark)
        begin
            if (data_byte == cfg.marker)
            begin
                res.record_start = 1'b1;
                line_next = 2'd0;
                if (is_brk)
                begin
                    res.out_byte = BYTE_ZERO;
                    res.line_kind = KIND_BREAK;
                    phase_next = PH_BREAK;
                end
                else
                begin
                    res.line_kind = 3'd0;
                    phase_next = PH_LINE;
                end
            end
            else
            begin
                phase_next = PH_ERROR;
            end
        end

        if (phase_next == PH_ERROR)
        begin
            res.out_byte = data_byte;
            res.line_kind = KIND_IGNORED;
            res.record_start = 1'b0;
            res.record_done = 1'b0;
            res.error_code = ERR_BAD_START;
        end
        else if (block_end && (phase_next == PH_LINE || phase_next == PH_BREAK)
                 && (line_next < last_line))
        begin
            res.error_code = ERR_TRUNCATED;
        end

        if (block_end)
        begin
            phase_next = PH_AWAIT;
            line_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_AWAIT;
            line_reg <= 2'd0;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            line_reg <= line_next;
        end
    end

endmodule

>>> rtl/fastq_fasta_record_splitter.sv
// FASTQ / FASTA record splitter.
// Input channel s_*: one raw text byte per word, s_tlast on the last byte of a block.
// Output channel m_*: one word per input word, same order. m_tdata carries the byte
// with CR/LF zeroed except on an error, m_tuser the line kind, record start/done flags
// and error code, m_tlast marks the end of the block (parser then awaits a new record).
// Configuration: cfg_we writes cfg_data into register cfg_addr (0 marker byte,
// 1 FASTQ mode); write only while no word is in flight.
// A word accepted into the input register is parsed combinationally and registered into
// the output register that drives m_*. Throughput is one word per cycle while m_tready
// is high, the parse state (phase and line index) being updated for each word.
// Reset clears the pipeline, returns the parser to await a record marker and loads
// marker '@' and FASTQ mode.
// When m_tready is low the output word holds; the input register still takes one
// more word, then s_tready drops until the output drains.
module fastq_fasta_record_splitter
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // block_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [7:0] m_tuser,   // [2:0] line_kind, [3] record_start,
                                  // [4] record_done, [6:5] error_code, [7] zero
    output logic       m_tlast,   // block_done
    input  logic       cfg_we,
    input  logic       cfg_addr,
    input  logic [7:0] cfg_data
);
    import fqfa_pkg::*;

    cfg_t       cfg;
    result_t    res;
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_reg;
    logic       out_adv;
    logic       in_adv;

    assign out_adv = !out_valid_reg || m_tready;
    assign in_adv = in_valid_reg && out_adv;
    assign s_tready = !in_valid_reg || out_adv;

    assign in_valid_next = (s_tvalid && s_tready) ? 1'b1 : (in_adv ? 1'b0 : in_valid_reg);
    assign out_valid_next = out_adv ? in_valid_reg : out_valid_reg;

    fqfa_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    fqfa_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (in_adv),
        .cfg       (cfg),
        .data_byte (in_byte_reg),
        .block_end (in_last_reg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (in_adv)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_reg.out_byte;
    assign m_tuser = {1'b0, out_reg.error_code, out_reg.record_done,
                      out_reg.record_start, out_reg.line_kind};
    assign m_tlast = out_reg.block_done;

endmodule
